@@ rtl/pfau_pkg.sv @@
// ----------------------------------------------------------------------------
// pfau_pkg: shared constants and types of the prime field arithmetic unit
// Operation codes, field width and the reset modulus.
// ----------------------------------------------------------------------------
`default_nettype none
package pfau_pkg;
  localparam int unsigned Width = 16;
  localparam int unsigned CntW = $clog2(Width + 1);
  localparam logic [Width-1:0] ResetModulus = Width'(137);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_INV = 3'd5
  } op_e;

  typedef struct packed {
    logic start;
    logic busy;
  } mm_ctl_t;
endpackage
`default_nettype wire

@@ rtl/prime_field_arith_unit.sv @@
// ----------------------------------------------------------------------------
// prime_field_arith_unit: modular arithmetic over Z_p
// Add, subtract, multiply, divide, power and inverse modulo a configured prime.
// ----------------------------------------------------------------------------
// Usage: write the prime into the modulus register via cfg_we_i/cfg_wdata_i
// while idle (reset value 137). Present an item on in_valid_i/in_ready_o with
// req_type_i, operand_a_i, operand_b_i. One result per item comes out on
// out_valid_o/out_ready_i.
// Both operands are first reduced by a restoring bit-serial divider, one
// after the other. Add and subtract are then computed in the dispatch state.
// Each multiply runs a start step, Width bit steps and a done step. Power scans
// the exponent LSB first, two multiplies per set exponent bit; inverse and
// divide use exponent p-2, divide adds one more multiply. Worst case is a
// power with an all-ones exponent. One item is in work at a time; the
// result register holds until taken and the next item waits for it.
// Reset clears the control state and restores the modulus to 137.
// ----------------------------------------------------------------------------
`default_nettype none
module prime_field_arith_unit import pfau_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [Width-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [2:0]       req_type_i,
  input  wire logic [Width-1:0] operand_a_i,
  input  wire logic [Width-1:0] operand_b_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [Width-1:0]      result_o
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_DISP = 4'd2,
    S_PMUL = 4'd3, S_PSQ = 4'd4, S_DMUL = 4'd5, S_OUT = 4'd6, S_MUL = 4'd7;

  logic [3:0]       st_q, st_d;
  logic [Width-1:0] p_q, res_q, res_d;
  logic [2:0]       op_q, op_d;
  logic [Width-1:0] a_q, a_d, b_q, b_d, braw_q, braw_d;
  logic [Width-1:0] acc_q, acc_d, base_q, base_d, ex_q, ex_d;
  logic [Width-1:0] rem_q, rem_d, sh_q, sh_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ph_q, ph_d;
  logic             mb_q, mb_d;
  logic [Width:0]   trial, sum;
  mm_ctl_t          mctl;
  logic [Width-1:0] mx, my, mprod;
  logic             mdone;

  pfau_modmul u_mul (
    .clk_i, .rst_ni, .ctl_i(mctl), .x_i(mx), .y_i(my), .p_i(p_q),
    .done_o(mdone), .prod_o(mprod)
  );

  always_comb begin
    st_d = st_q; res_d = res_q; op_d = op_q; a_d = a_q; b_d = b_q;
    braw_d = braw_q; acc_d = acc_q; base_d = base_q; ex_d = ex_q;
    rem_d = rem_q; sh_d = sh_q; cnt_d = cnt_q; ph_d = ph_q; mb_d = mb_q;
    mctl = '0; mx = acc_q; my = base_q;
    trial = {rem_q, sh_q[Width-1]};
    sum = '0;
    unique case (st_q)
      S_IDLE: if (in_valid_i) begin
        op_d = req_type_i; braw_d = operand_b_i;
        rem_d = '0; sh_d = operand_a_i; cnt_d = CntW'(Width); ph_d = 1'b0;
        st_d = (p_q < Width'(2)) ? S_OUT : S_RED;
        res_d = '0;
      end
      S_RED: begin
        // restoring division step, one bit per cycle
        if (trial >= {1'b0, p_q}) trial = trial - {1'b0, p_q};
        rem_d = trial[Width-1:0];
        sh_d = {sh_q[Width-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          if (!ph_q) begin
            a_d = trial[Width-1:0]; ph_d = 1'b1; rem_d = '0;
            sh_d = braw_q; cnt_d = CntW'(Width);
          end else begin
            b_d = trial[Width-1:0]; st_d = S_DISP;
          end
        end
      end
      S_DISP: begin
        acc_d = (p_q == Width'(1)) ? '0 : Width'(1);
        mb_d = 1'b0;
        unique case (op_q)
          OP_ADD: begin
            sum = {1'b0, a_q} + {1'b0, b_q};
            if (sum >= {1'b0, p_q}) sum = sum - {1'b0, p_q};
            res_d = sum[Width-1:0]; st_d = S_OUT;
          end
          OP_SUB: begin
            sum = {1'b0, a_q} + {1'b0, p_q} - {1'b0, b_q};
            if (sum >= {1'b0, p_q}) sum = sum - {1'b0, p_q};
            res_d = sum[Width-1:0]; st_d = S_OUT;
          end
          OP_MUL: begin
            mctl.start = 1'b1; mctl.busy = 1'b1;
            mx = a_q; my = b_q; st_d = S_MUL;
          end
          OP_POW: begin
            base_d = a_q; ex_d = braw_q; st_d = S_PMUL;
          end
          OP_INV, OP_DIV: begin
            base_d = (op_q == OP_INV) ? a_q : b_q;
            ex_d = p_q - Width'(2);
            if (base_d == '0) begin
              res_d = '0; st_d = S_OUT;
            end else st_d = S_PMUL;
          end
          default: begin
            res_d = '0; st_d = S_OUT;
          end
        endcase
      end
      S_MUL: begin
        // hold the multiplicand while the multiplier runs
        mx = a_q;
        mctl.busy = 1'b1;
        if (mdone) begin
          res_d = mprod; st_d = S_OUT;
        end
      end
      S_PMUL: begin
        // multiply step of the square-and-multiply loop; also passes clear exponent bits on and ends the loop
        if (ex_q == '0) begin
          if (op_q == OP_DIV) begin
            mctl.start = 1'b1; mctl.busy = 1'b1;
            mx = a_q; my = acc_q; st_d = S_DMUL;
          end else begin
            res_d = acc_q; st_d = S_OUT;
          end
        end else if (!ex_q[0]) begin
          st_d = S_PSQ; mb_d = 1'b0;
        end else if (!mb_q) begin
          mctl.start = 1'b1; mctl.busy = 1'b1; mb_d = 1'b1;
        end else begin
          mctl.busy = 1'b1;
          if (mdone) begin
            acc_d = mprod; st_d = S_PSQ; mb_d = 1'b0;
          end
        end
      end
      S_PSQ: begin
        mx = base_q; my = base_q;
        if (!mb_q) begin
          mctl.start = 1'b1; mctl.busy = 1'b1; mb_d = 1'b1;
        end else begin
          mctl.busy = 1'b1;
          if (mdone) begin
            base_d = mprod; ex_d = ex_q >> 1; mb_d = 1'b0; st_d = S_PMUL;
          end
        end
      end
      S_DMUL: begin
        mx = a_q;
        mctl.busy = 1'b1;
        if (mdone) begin
          res_d = mprod; st_d = S_OUT;
        end
      end
      S_OUT: if (out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; p_q <= ResetModulus; mb_q <= 1'b0;
      ph_q <= 1'b0; cnt_q <= '0;
    end else begin
      st_q <= st_d; mb_q <= mb_d; ph_q <= ph_d; cnt_q <= cnt_d;
      if (cfg_we_i) p_q <= cfg_wdata_i;
    end
  end
  always_ff @(posedge clk_i) begin
    res_q <= res_d; op_q <= op_d; a_q <= a_d; b_q <= b_d; braw_q <= braw_d;
    acc_q <= acc_d; base_q <= base_d; ex_q <= ex_d; rem_q <= rem_d; sh_q <= sh_d;
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign result_o    = res_q;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_res_below_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && p_q >= Width'(2) |-> result_o < p_q) else $error("result not reduced");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result dropped");
`endif
endmodule
`default_nettype wire

@@ rtl/pfau_modmul.sv @@
// ----------------------------------------------------------------------------
// pfau_modmul: bit-serial modular multiplier
// Computes x*y mod p by MSB-first double-and-add, one bit of y per cycle.
// Inputs x, y must already be below p.
// ----------------------------------------------------------------------------
`default_nettype none
module pfau_modmul import pfau_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mm_ctl_t          ctl_i,
  input  wire logic [Width-1:0] x_i,
  input  wire logic [Width-1:0] y_i,
  input  wire logic [Width-1:0] p_i,
  output logic                  done_o,
  output logic [Width-1:0]      prod_o
);
  logic [Width-1:0] acc_q, acc_d, y_q, y_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic [Width:0]   dbl, dblr, add;

  always_comb begin
    dbl  = {acc_q, 1'b0};
    dblr = (dbl >= {1'b0, p_i}) ? dbl - {1'b0, p_i} : dbl;
    add  = dblr + (y_q[Width-1] ? {1'b0, x_i} : '0);
    if (add >= {1'b0, p_i}) add = add - {1'b0, p_i};
    acc_d = acc_q; y_d = y_q; cnt_d = cnt_q; run_d = run_q;
    if (ctl_i.start) begin
      acc_d = '0; y_d = y_i; cnt_d = CntW'(Width); run_d = 1'b1;
    end else if (run_q) begin
      acc_d = add[Width-1:0];
      y_d   = {y_q[Width-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; y_q <= y_d;
  end

  assign done_o = ctl_i.busy && !run_q && !ctl_i.start;
  assign prod_o = acc_q;
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for prime_field_arith_unit
// Drives directed and random items through several moduli, prime and not (0, 1, 65535), predicts
// each result with a behavioral model and compares it against the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import pfau_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 700;

  typedef struct packed {
    logic [2:0]       op;
    logic [Width-1:0] a;
    logic [Width-1:0] b;
  } arith_req_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [Width-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [2:0]       req_type_i = '0;
  logic [Width-1:0] operand_a_i = '0;
  logic [Width-1:0] operand_b_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [Width-1:0] result_o;

  arith_req_t       pending_reqs[$];
  logic [Width-1:0] expected_results[$];
  logic [Width-1:0] field_prime = ResetModulus;
  int unsigned      mismatches = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      send_gap = 0;
  int unsigned      take_gap = 0;
  bit               in_taken = 1'b0;
  bit               out_taken = 1'b0;
  bit               timed_out = 1'b0;

  prime_field_arith_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] ex,
                                          logic [63:0] p);
    logic [63:0] acc;
    acc = 1 % p;
    base = base % p;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * base) % p;
      ex = ex >> 1;
      base = (base * base) % p;
    end
    return acc;
  endfunction

  function automatic logic [63:0] inv_mod(logic [63:0] v, logic [63:0] p);
    v = v % p;
    if (v == 0) return 0;
    return pow_mod(v, p - 2, p);
  endfunction

  function automatic logic [Width-1:0] field_result(arith_req_t req,
                                                    logic [Width-1:0] prime);
    logic [63:0] p, ar, br, r;
    p = prime;
    r = 0;
    if (p >= 2) begin
      ar = req.a % p;
      br = req.b % p;
      case (req.op)
        OP_ADD: r = (ar + br) % p;
        OP_SUB: r = (ar + ((p - br) % p)) % p;
        OP_MUL: r = (ar * br) % p;
        OP_DIV: r = (ar * inv_mod(br, p)) % p;
        OP_POW: r = pow_mod(ar, req.b, p);
        OP_INV: r = inv_mod(ar, p);
        default: r = 0;
      endcase
    end
    return r[Width-1:0];
  endfunction

  // Driver: present queued items with a random gap after each accept, and raise out_ready_i after a random gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        send_gap <= $urandom_range(0, 15);
        void'(pending_reqs.pop_front());
        in_valid_i <= 1'b0;
      end else if (!in_valid_i) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() != 0) begin
          in_valid_i <= 1'b1;
          req_type_i <= pending_reqs[0].op;
          operand_a_i <= pending_reqs[0].a;
          operand_b_i <= pending_reqs[0].b;
        end
      end
      if (out_taken) begin
        out_ready_i <= 1'b0;
        take_gap <= $urandom_range(0, 15);
      end else if (!out_ready_i) begin
        if (take_gap != 0) take_gap <= take_gap - 1;
        else out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on accept, check on result, and end the run as failed on a stall.
  always @(posedge clk_i) begin
    arith_req_t req;
    logic [Width-1:0] want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
      if (in_valid_i && in_ready_o) begin
        req = '{op: req_type_i, a: operand_a_i, b: operand_b_i};
        expected_results.push_back(field_result(req, field_prime));
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %0d", result_o);
        end else begin
          want = expected_results.pop_front();
          if (result_o !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("result mismatch: expected %0d actual %0d (p=%0d)",
                       want, result_o, field_prime);
          end
        end
      end
      if (moved) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic queue_req(logic [2:0] op, logic [Width-1:0] a,
                           logic [Width-1:0] b);
    pending_reqs.push_back('{op: op, a: a, b: b});
  endtask

  // Wait until idle, then write a new modulus.
  task automatic set_prime(logic [Width-1:0] prime);
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= prime;
    field_prime = prime;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_burst(int unsigned count);
    logic [2:0] op;
    for (int unsigned i = 0; i < count; i++) begin
      op = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 3))
        0: queue_req(op, Width'($urandom_range(0, 3)), Width'($urandom));
        1: queue_req(op, Width'($urandom), Width'($urandom_range(0, 3)));
        default: queue_req(op, Width'($urandom), Width'($urandom));
      endcase
    end
  endtask

  initial begin
    logic [Width-1:0] primes[7];
    primes = '{16'd65521, 16'd2, 16'd3, 16'd251, 16'd0, 16'd1, 16'd65535};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: each operation at extremes, zero inverse, zero exponent, unused codes.
    queue_req(OP_ADD, 16'hFFFF, 16'hFFFF);
    queue_req(OP_SUB, 16'd0, 16'hFFFF);
    queue_req(OP_SUB, 16'd5, 16'd137);
    queue_req(OP_MUL, 16'hFFFF, 16'hFFFF);
    queue_req(OP_DIV, 16'd100, 16'd0);
    queue_req(OP_DIV, 16'd100, 16'd274);
    queue_req(OP_DIV, 16'hFFFF, 16'd3);
    queue_req(OP_POW, 16'd0, 16'd0);
    queue_req(OP_POW, 16'd7, 16'd0);
    queue_req(OP_POW, 16'hFFFF, 16'hFFFF);
    queue_req(OP_INV, 16'd0, 16'd0);
    queue_req(OP_INV, 16'd137, 16'd1);
    queue_req(OP_INV, 16'd136, 16'hFFFF);
    queue_req(3'd6, 16'd9, 16'd9);
    queue_req(3'd7, 16'hFFFF, 16'hFFFF);
    random_burst(80);

    foreach (primes[i]) begin
      set_prime(primes[i]);
      random_burst(i == 0 ? 80 : 35);
    end
    set_prime(16'd137);
    random_burst(30);

    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/pfau_pkg.sv
rtl/pfau_modmul.sv
rtl/prime_field_arith_unit.sv
tb/sv/tb.sv
